// ===== hdl/xlb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the XOR linear basis block: sizes, controller states and the
// command and status structs between the controller and the datapath. No dependencies.
package xlb_pkg;

    localparam int VEC_BITS = 61;
    localparam int POS_W    = $clog2(VEC_BITS);
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(VEC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } xlb_state_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_CHECK  = 1'b1
    } xlb_op_t;

    typedef struct packed {
        logic load;
        logic step;
        logic write_row;
        logic emit;
    } xlb_cmd_t;

    typedef struct packed {
        logic hit_empty;
        logic at_bottom;
        logic is_check;
        logic out_busy;
    } xlb_status_t;

endpackage

// ===== hdl/xor_linear_basis.sv =====
`timescale 1ns / 1ps
// Top level of the XOR linear basis block: a GF(2) basis of 61-bit vectors.
// Depends on xlb_pkg, xlb_ctrl, xlb_datapath (and through it xlb_ram).
//
//  Channel | Direction | tdata                      | tuser
//  --------+-----------+----------------------------+-----------------------------
//  s_      | request   | [60:0] value, [63:61] zero | [0] operation (0 ins, 1 chk)
//  m_      | result    | [0] in_span, [7:1] zero    | none
//
// An item is accepted in the idle state, then the walk visits bit positions in turn from
// bit 60 down, never below bit 0; no new request is taken until it is done. The walk reads
// one basis row a cycle from the row RAM's single read port; an insert stops where it
// is stored and a check stops at the first set bit with an empty row (in_span zero).
// Reset clears the row valid bits at once, with no clearing pass. A finished check
// holds its walk while an earlier result waits for m_tready; inserts give no result.
module xor_linear_basis
    import xlb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [60:0] value, [63:61] zero padding
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] in_span, [7:1] zero padding
);

    xlb_cmd_t    cmd;
    xlb_status_t status;
    logic        in_span;

    // The controller owns the sequence; the datapath does the reduction.
    xlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The padding bits of s_tdata above the vector are not used.
    xlb_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_value    (s_tdata[VEC_BITS-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_in_span (in_span)
    );

    assign m_tdata = {7'b0, in_span};

endmodule

// ===== hdl/xlb_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. No dependencies.
module xlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/xlb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the XOR linear basis block: sequences the walk over bit positions.
// Depends on xlb_pkg.
module xlb_ctrl
    import xlb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  xlb_status_t status,
    output xlb_cmd_t    cmd
);

    xlb_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status.hit_empty || status.at_bottom) begin
                    if (status.is_check) begin
                        // Hold the walk until the result register is free.
                        if (!status.out_busy) begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.write_row = status.hit_empty;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/xlb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the XOR linear basis block: working vector, position counter,
// row valid bits, basis row RAM and result register. Depends on xlb_pkg and xlb_ram.
module xlb_datapath
    import xlb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  xlb_cmd_t            cmd,
    output xlb_status_t         status,
    input  logic                in_op,
    input  logic [VEC_BITS-1:0] in_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_in_span
);

    logic [VEC_BITS-1:0] v_reg, v_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                op_reg, op_next;
    logic [VEC_BITS-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                in_span_reg, in_span_next;
    logic [VEC_BITS-1:0] row_data;
    logic                cur_bit;
    logic                cur_row_valid;

    assign cur_bit       = v_reg[pos_reg];
    assign cur_row_valid = valid_reg[pos_reg];

    assign status.hit_empty = cur_bit && !cur_row_valid;
    assign status.at_bottom = (pos_reg == '0);
    assign status.is_check  = (op_reg == OP_CHECK);
    assign status.out_busy  = out_valid_reg && !out_ready;

    // The read address is the next position, so the row is ready when the
    // walk reaches it.
    xlb_ram #(
        .WIDTH (VEC_BITS),
        .DEPTH (VEC_BITS)
    ) u_rows (
        .aclk  (aclk),
        .we    (cmd.write_row),
        .waddr (pos_reg),
        .wdata (v_reg),
        .raddr (pos_next),
        .rdata (row_data)
    );

    always_comb begin
        v_next         = v_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        in_span_next   = in_span_reg;

        if (cmd.load) begin
            v_next   = in_value;
            op_next  = in_op;
            pos_next = TOP_POS;
        end

        if (cmd.step) begin
            if (cur_bit && cur_row_valid) begin
                v_next = v_reg ^ row_data;
            end
            pos_next = pos_reg - POS_W'(1);
        end

        if (cmd.write_row) begin
            valid_next[pos_reg] = 1'b1;
        end

        if (cmd.emit) begin
            out_valid_next = 1'b1;
            in_span_next   = !status.hit_empty;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
        v_reg       <= v_next;
        pos_reg     <= pos_next;
        op_reg      <= op_next;
        in_span_reg <= in_span_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_in_span = in_span_reg;

endmodule
